/* src/fema_pkg.sv */
// Shared types and constants for the free extent map allocator.
`default_nettype none
package fema_pkg;
  localparam int MaxEntries = 256;
  localparam int IdxW       = $clog2(MaxEntries);
  localparam int CntW       = $clog2(MaxEntries + 1);
  localparam int AddrW      = 48;
  localparam int UnitW      = 21;
  localparam int CapW       = 9;
  localparam logic [AddrW-1:0] AddrTop = {AddrW{1'b1}};

  localparam logic [1:0] StOk   = 2'd0;
  localparam logic [1:0] StNone = 2'd1;
  localparam logic [1:0] StFull = 2'd2;

  localparam logic CmdFree  = 1'b0;
  localparam logic CmdAlloc = 1'b1;

  localparam logic [0:0] CfgUnit = 1'b0;
  localparam logic [0:0] CfgCap  = 1'b1;

  // Operation broadcast from the controller to every cell.
  typedef enum logic [2:0] {
    OP_NONE,
    OP_SET,      // write entry at sel
    OP_INSERT,   // shift right from sel, write at sel
    OP_DROP,     // shift left from sel (entry sel is removed)
    OP_SETDROP   // write entry at sel, shift left from sel+1
  } cell_op_t;

  typedef struct packed {
    cell_op_t         op;
    logic [IdxW-1:0]  sel;
    logic [AddrW-1:0] start;
    logic [AddrW-1:0] len;
  } cell_cmd_t;
endpackage
`default_nettype wire

/* src/fema_cell.sv */
// One entry of the sorted extent row: holds start/length, shifts with neighbors.
`default_nettype none
module fema_cell
  import fema_pkg::*;
(
  input  wire logic             clk,
  input  wire logic [IdxW-1:0]  my_idx,
  input  wire cell_cmd_t        cmd,
  input  wire logic [AddrW-1:0] left_start,
  input  wire logic [AddrW-1:0] left_len,
  input  wire logic [AddrW-1:0] right_start,
  input  wire logic [AddrW-1:0] right_len,
  input  wire logic [AddrW-1:0] key,
  output logic [AddrW-1:0]      start_o,
  output logic [AddrW-1:0]      len_o,
  output logic                  below_o   // start < key
);
  logic [AddrW-1:0] start_r, len_r, start_nxt, len_nxt;

  // Local next value from the broadcast operation
  always_comb begin
    start_nxt = start_r;
    len_nxt   = len_r;
    unique case (cmd.op)
      OP_SET: begin
        if (my_idx == cmd.sel) begin
          start_nxt = cmd.start; len_nxt = cmd.len;
        end
      end
      OP_INSERT: begin
        if (my_idx == cmd.sel) begin
          start_nxt = cmd.start; len_nxt = cmd.len;
        end else if (my_idx > cmd.sel) begin
          start_nxt = left_start; len_nxt = left_len;
        end
      end
      OP_DROP: begin
        if (my_idx >= cmd.sel) begin
          start_nxt = right_start; len_nxt = right_len;
        end
      end
      OP_SETDROP: begin
        if (my_idx == cmd.sel) begin
          start_nxt = cmd.start; len_nxt = cmd.len;
        end else if (my_idx > cmd.sel) begin
          start_nxt = right_start; len_nxt = right_len;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    start_r <= start_nxt;
    len_r   <= len_nxt;
  end

  assign start_o = start_r;
  assign len_o   = len_r;
  assign below_o = start_r < key;
endmodule
`default_nettype wire

/* src/free_extent_map_allocator_top.sv */
// Top level of the free extent map allocator: control, cell row and output stage.
// A command is taken in one cycle and executed in the next. In the transfer cycle
// every cell compares its start against the incoming offset in parallel and the
// compare row is captured. In the execute cycle the controller finds the first
// entry not below the offset for a free (an alloc uses entry 0), picks the neighbors
// and broadcasts one set/insert/drop operation that every cell applies, shifting with
// its neighbor where the operation asks for it. The result sits in an output
// register. The input stays closed while a result waits, so a new command is taken
// only after the result has been handed over. No clearing pass after reset.
`default_nettype none
module free_extent_map_allocator_top
  import fema_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire logic             in_cmd,
  input  wire logic [AddrW-1:0] in_offset,
  input  wire logic [AddrW-1:0] in_length,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output logic [1:0]            out_status,
  output logic [AddrW-1:0]      out_alloc_offset,
  input  wire logic             cfg_we,
  input  wire logic [0:0]       cfg_index,
  input  wire logic [UnitW-1:0] cfg_wdata
);
  typedef enum logic {S_IDLE, S_EXEC} state_t;
  state_t state_r;

  logic [UnitW-1:0] unit_r;
  logic [CapW-1:0]  cap_r;
  logic [CntW-1:0]  count_r;
  logic             cmd_r;
  logic [AddrW-1:0] off_r, len_r;
  logic             ov_r;
  logic [1:0]       ost_r;
  logic [AddrW-1:0] oofs_r;

  logic [AddrW-1:0] cs [MaxEntries];
  logic [AddrW-1:0] cl [MaxEntries];
  logic [MaxEntries-1:0] below;
  logic [MaxEntries-1:0] below_r;
  cell_cmd_t ccmd;

  // Cell row
  for (genvar g = 0; g < MaxEntries; g++) begin : g_cell
    logic [AddrW-1:0] ls, ll, rs, rl;
    if (g == 0) begin : g_l0
      assign ls = '0; assign ll = '0;
    end else begin : g_l
      assign ls = cs[g-1]; assign ll = cl[g-1];
    end
    if (g == MaxEntries-1) begin : g_rn
      assign rs = '0; assign rl = '0;
    end else begin : g_r
      assign rs = cs[g+1]; assign rl = cl[g+1];
    end
    fema_cell u_cell (
      .clk(clk), .my_idx(IdxW'(g)), .cmd(ccmd),
      .left_start(ls), .left_len(ll), .right_start(rs), .right_len(rl),
      .key(in_offset), .start_o(cs[g]), .len_o(cl[g]), .below_o(below[g]));
  end

  // nx = first valid entry whose start is not below offset, else count
  logic [CntW-1:0] nx;
  always_comb begin
    nx = count_r;
    for (int i = MaxEntries - 1; i >= 0; i--)
      if ((CntW'(i) < count_r) && !below_r[i]) nx = CntW'(i);
  end

  logic [IdxW-1:0]  pv_i, nx_i;
  logic [AddrW-1:0] clen, fend, pv_s, pv_l, nx_s, nx_l;
  logic             has_pv, has_nx, join_l, join_r, full;
  logic [CntW-1:0]  cap_eff;
  logic [1:0]       st;
  logic [AddrW-1:0] gofs;
  logic [CntW-1:0]  count_nxt;

  assign pv_i   = IdxW'(nx - 1'b1);
  assign nx_i   = nx[IdxW-1:0];
  assign has_pv = nx != '0;
  assign has_nx = nx < count_r;
  assign pv_s   = cs[pv_i];
  assign pv_l   = cl[pv_i];
  assign nx_s   = cs[nx_i];
  assign nx_l   = cl[nx_i];
  assign clen   = (len_r > (AddrTop - off_r)) ? (AddrTop - off_r) : len_r;
  assign fend   = off_r + clen;
  assign join_l = has_pv && (pv_s + pv_l == off_r);
  assign join_r = has_nx && (nx_s == fend);
  assign cap_eff = ({1'b0, cap_r} > CntW'(MaxEntries)) ? CntW'(MaxEntries)
                                                       : CntW'(cap_r);
  assign full   = count_r >= cap_eff;

  // Decide the row operation for the command held in off_r/len_r
  always_comb begin
    ccmd      = '{op: OP_NONE, sel: '0, start: '0, len: '0};
    st        = StOk;
    gofs      = '0;
    count_nxt = count_r;
    if (state_r == S_EXEC) begin
      if (cmd_r == CmdAlloc) begin
        if (count_r == '0) begin
          st = StNone;
        end else begin
          gofs = cs[0];
          if (AddrW'(unit_r) < cl[0]) begin
            ccmd = '{op: OP_SET, sel: '0, start: cs[0] + AddrW'(unit_r),
                     len: cl[0] - AddrW'(unit_r)};
          end else begin
            ccmd.op   = OP_DROP;
            count_nxt = count_r - 1'b1;
          end
        end
      end else if (clen != '0) begin
        priority if (join_l && join_r) begin
          ccmd = '{op: OP_SETDROP, sel: pv_i, start: pv_s,
                   len: nx_s + nx_l - pv_s};
          count_nxt = count_r - 1'b1;
        end else if (join_l) begin
          ccmd = '{op: OP_SET, sel: pv_i, start: pv_s, len: fend - pv_s};
        end else if (join_r) begin
          ccmd = '{op: OP_SET, sel: nx_i, start: off_r, len: nx_s + nx_l - off_r};
        end else if (full) begin
          st = StFull;
        end else begin
          ccmd = '{op: OP_INSERT, sel: nx_i, start: off_r, len: clen};
          count_nxt = count_r + 1'b1;
        end
      end
    end
  end

  assign in_ready = (state_r == S_IDLE) && !ov_r;

  // Control and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      count_r <= '0;
      ov_r    <= 1'b0;
      unit_r  <= UnitW'(4096);
      cap_r   <= CapW'(256);
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          CfgUnit: unit_r <= cfg_wdata;
          CfgCap:  cap_r  <= cfg_wdata[CapW-1:0];
          default: ;
        endcase
      end
      if (out_valid && out_ready) ov_r <= 1'b0;
      unique case (state_r)
        S_IDLE: if (in_valid && in_ready) state_r <= S_EXEC;
        S_EXEC: begin
          state_r <= S_IDLE;
          count_r <= count_nxt;
          ov_r    <= 1'b1;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // Payload registers; compare row is captured with the command
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      cmd_r   <= in_cmd;
      off_r   <= in_offset;
      len_r   <= in_length;
      below_r <= below;
    end
    if (state_r == S_EXEC) begin
      ost_r  <= st;
      oofs_r <= gofs;
    end
  end

  assign out_valid        = ov_r;
  assign out_status       = ost_r;
  assign out_alloc_offset = oofs_r;

  a_count_max: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CntW'(MaxEntries)) else $error("entry count overflow");
  a_exec_one: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_EXEC |=> state_r == S_IDLE && out_valid) else $error("exec stuck");
  a_full_nogrow: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_EXEC && st == StFull) |=> $stable(count_r))
    else $error("full insert changed count");
endmodule
`default_nettype wire

/* dv/free_extent_map_allocator_top_tb.sv */
// Self-checking testbench for the free extent map allocator top level.
`default_nettype none
module free_extent_map_allocator_top_tb;
  import fema_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic [1:0]       status;
    logic [AddrW-1:0] alloc_offset;
  } extent_result_t;

  // Shadow of the extent table; predicts one result per accepted command
  class extent_scoreboard;
    logic [AddrW-1:0] ext_start [MaxEntries];
    logic [AddrW-1:0] ext_len [MaxEntries];
    int               ext_count;
    logic [UnitW-1:0] unit_len;
    logic [CapW-1:0]  cap_limit;
    extent_result_t   pending_q[$];
    int               errors;

    function new();
      ext_count = 0;
      unit_len  = UnitW'(4096);
      cap_limit = CapW'(256);
      errors    = 0;
    endfunction

    function void write_reg(logic [0:0] idx, logic [UnitW-1:0] data);
      if (idx == CfgUnit) unit_len = data;
      else cap_limit = data[CapW-1:0];
    endfunction

    function void remove_at(int pos);
      for (int i = pos; i + 1 < ext_count; i++) begin
        ext_start[i] = ext_start[i+1];
        ext_len[i]   = ext_len[i+1];
      end
      if (ext_count > 0) ext_count--;
    endfunction

    function logic [1:0] free_extent(logic [AddrW-1:0] off, logic [AddrW-1:0] len);
      logic [AddrW-1:0] range_end;
      logic [AddrW-1:0] right_end;
      int nx;
      int pv;
      int lim;
      bit joined;
      nx = 0;
      pv = 0;
      joined = 0;
      // clip at top of the address space
      if (len > AddrTop - off) len = AddrTop - off;
      if (len == 0) return StOk;
      range_end = off + len;
      while (nx < ext_count && ext_start[nx] < off) nx++;
      if (nx > 0) begin
        pv = nx - 1;
        if ({1'b0, ext_start[pv]} + ext_len[pv] == {1'b0, off}) begin
          ext_len[pv] = range_end - ext_start[pv];
          joined = 1;
        end
      end
      if (nx < ext_count && ext_start[nx] == range_end) begin
        right_end = ext_start[nx] + ext_len[nx];
        if (joined) begin
          ext_len[pv] = right_end - ext_start[pv];
          remove_at(nx);
        end else begin
          ext_start[nx] = off;
          ext_len[nx]   = right_end - off;
        end
        return StOk;
      end
      if (joined) return StOk;
      lim = (cap_limit < MaxEntries) ? int'(cap_limit) : MaxEntries;
      if (ext_count >= lim) return StFull;
      for (int i = ext_count; i > nx; i--) begin
        ext_start[i] = ext_start[i-1];
        ext_len[i]   = ext_len[i-1];
      end
      ext_start[nx] = off;
      ext_len[nx]   = len;
      ext_count++;
      return StOk;
    endfunction

    // Note one accepted command and queue its expected result
    function void note_command(logic cmd, logic [AddrW-1:0] off, logic [AddrW-1:0] len);
      extent_result_t r;
      r.status = StOk;
      r.alloc_offset = '0;
      if (cmd == CmdFree) begin
        r.status = free_extent(off, len);
      end else if (ext_count == 0) begin
        r.status = StNone;
      end else begin
        r.alloc_offset = ext_start[0];
        if ({27'd0, unit_len} < ext_len[0]) begin
          ext_start[0] += {27'd0, unit_len};
          ext_len[0]   -= {27'd0, unit_len};
        end else begin
          remove_at(0);
        end
      end
      pending_q.push_back(r);
    endfunction

    function void check_result(logic [1:0] st, logic [AddrW-1:0] ao);
      extent_result_t r;
      if (pending_q.size() == 0) begin
        $error("unexpected result transfer: status %0d alloc_offset %h", st, ao);
        errors++;
        return;
      end
      r = pending_q.pop_front();
      if (st !== r.status) begin
        $error("status mismatch: expected %0d actual %0d", r.status, st);
        errors++;
      end
      if (ao !== r.alloc_offset) begin
        $error("alloc_offset mismatch: expected %h actual %h", r.alloc_offset, ao);
        errors++;
      end
    endfunction
  endclass

  localparam int WatchdogLimit = 5000;
  localparam logic [AddrW-1:0] WinBase = 48'h0000_1000_0000;

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             in_valid = 1'b0;
  logic             in_ready;
  logic             in_cmd = CmdFree;
  logic [AddrW-1:0] in_offset = '0;
  logic [AddrW-1:0] in_length = '0;
  logic             out_valid;
  logic             out_ready = 1'b0;
  logic [1:0]       out_status;
  logic [AddrW-1:0] out_alloc_offset;
  logic             cfg_we = 1'b0;
  logic [0:0]       cfg_index = CfgUnit;
  logic [UnitW-1:0] cfg_wdata = '0;

  int tx_idle_pct = 29;
  int rx_idle_pct = 73;
  int stall_cnt = 0;
  extent_scoreboard sb = new();

  free_extent_map_allocator_top DUT (.*);

  always #10 clk = ~clk;

  // Result side: check each transfer, stall at random
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) sb.check_result(out_status, out_alloc_offset);
    out_ready <= ($urandom_range(99) >= rx_idle_pct);
  end

  // Watchdog on cycles without any transfer
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      stall_cnt <= 0;
    end else begin
      stall_cnt <= stall_cnt + 1;
      if (stall_cnt >= WatchdogLimit) begin
        $display("free_extent_map_allocator_top regression: fail");
        $finish;
      end
    end
  end

  // Drive one command and hold it until the transfer
  task automatic send_cmd(logic cmd, logic [AddrW-1:0] off, logic [AddrW-1:0] len);
    if ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    in_valid  <= 1'b1;
    in_cmd    <= cmd;
    in_offset <= off;
    in_length <= len;
    do @(posedge clk); while (!in_ready);
    sb.note_command(cmd, off, len);
  endtask

  task automatic drain();
    if (in_valid) in_valid <= 1'b0;
    while (sb.pending_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_cfg(logic [0:0] idx, logic [UnitW-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    sb.write_reg(idx, data);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic [AddrW-1:0] rand_addr();
    logic [63:0] r;
    r = {$urandom(), $urandom()};
    return r[AddrW-1:0];
  endfunction

  // Frees that touch existing extents or land in a fixed window, plus allocs and noise
  task automatic send_random();
    int sel;
    int k;
    logic [AddrW-1:0] off;
    logic [AddrW-1:0] len;
    sel = $urandom_range(99);
    len = AddrW'($urandom_range(1, 4) * 4096);
    if (sel < 30) begin
      send_cmd(CmdAlloc, rand_addr(), rand_addr());
    end else if (sel < 50 && sb.ext_count > 0) begin
      k = $urandom_range(sb.ext_count - 1);
      send_cmd(CmdFree, sb.ext_start[k] + sb.ext_len[k], len);
    end else if (sel < 65 && sb.ext_count > 0) begin
      k = $urandom_range(sb.ext_count - 1);
      off = (sb.ext_start[k] >= len) ? sb.ext_start[k] - len : '0;
      send_cmd(CmdFree, off, len);
    end else if (sel < 88) begin
      off = WinBase + AddrW'($urandom_range(63) * 4096);
      send_cmd(CmdFree, off, len);
    end else begin
      off = rand_addr();
      len = ($urandom_range(9) == 0) ? ($urandom_range(1) ? AddrTop : '0) : rand_addr();
      send_cmd(1'($urandom_range(1)), off, len);
    end
  endtask

  initial begin
    logic [UnitW-1:0] unit_set [6];
    logic [CapW-1:0]  cap_set [6];
    unit_set = '{21'd4096, 21'd1, 21'd0, 21'h1FFFFF, 21'd16, 21'd1048576};
    cap_set  = '{9'd256, 9'd4, 9'd0, 9'd511, 9'd3, 9'd64};
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: empty alloc, joins, clipping, empty range, duplicates
    send_cmd(CmdAlloc, '0, '0);
    send_cmd(CmdFree, 48'h1000, 48'h1000);
    send_cmd(CmdFree, 48'h3000, 48'h1000);
    send_cmd(CmdFree, 48'h2000, 48'h1000);
    send_cmd(CmdFree, 48'h0, 48'h1000);
    send_cmd(CmdFree, 48'h8000, 48'h1000);
    send_cmd(CmdFree, 48'h9000, 48'h800);
    send_cmd(CmdFree, 48'h7800, 48'h800);
    send_cmd(CmdFree, 48'h8000, 48'h1000);
    send_cmd(CmdFree, 48'h8800, 48'h100);
    send_cmd(CmdFree, AddrTop, 48'h5);
    send_cmd(CmdFree, AddrTop - 48'h10, AddrTop);
    send_cmd(CmdFree, 48'h20000, 48'h0);
    send_cmd(CmdFree, 48'h0, AddrTop);
    for (int i = 0; i < 8; i++) send_cmd(CmdAlloc, AddrTop, AddrTop);
    drain();

    // Random phases across idling modes and register settings
    for (int m = 0; m < 3; m++) begin
      tx_idle_pct = (m == 0) ? 29 : (m == 1) ? 73 : 0;
      rx_idle_pct = (m == 0) ? 73 : (m == 1) ? 29 : 0;
      for (int s = 0; s < 6; s++) begin
        write_cfg(CfgUnit, unit_set[(s + m) % 6]);
        write_cfg(CfgCap, {12'd0, cap_set[(s + 2 * m) % 6]});
        for (int i = 0; i < 78; i++) send_random();
        drain();
      end
    end

    repeat (10) @(posedge clk);
    if (sb.errors == 0 && sb.pending_q.size() == 0) begin
      $display("free_extent_map_allocator_top regression: pass");
    end else begin
      $display("free_extent_map_allocator_top regression: fail");
    end
    $finish;
  end
endmodule
`default_nettype wire

/* files.f */
src/fema_pkg.sv
src/fema_cell.sv
src/free_extent_map_allocator_top.sv
dv/free_extent_map_allocator_top_tb.sv
